### src/psda_pkg.sv
package psda_pkg;

	// Window depth of the boxcar; must be a power of two so the average is a shift.
	localparam int DEPTH      = 8;
	localparam int DEPTH_LOG2 = $clog2(DEPTH);
	localparam int POS_W      = (DEPTH_LOG2 > 0) ? DEPTH_LOG2 : 1;

	localparam int SAMPLE_W = 10;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int WRAP_W   = 16;

	// Sign bit plus enough magnitude bits for DEPTH full-scale differences.
	localparam int SUM_W = $clog2(DEPTH * ((1 << SAMPLE_W) - 1) + 1) + 1;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(DEPTH - 1);

	// Request codes carried in req_type.
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic [WRAP_W-1:0]   wrap_count;
		logic                expect_peak;
	} result_t;

endpackage

### src/psda_datapath.sv
module psda_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  psda_pkg::item_t  item,
	output psda_pkg::result_t result
);
	import psda_pkg::*;

	logic [SAMPLE_W-1:0]      peak_q;
	logic                     phase_peak_q;
	logic signed [DIFF_W-1:0] ring_q [DEPTH];
	logic [POS_W-1:0]         pos_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [WRAP_W-1:0]        wrap_q;

	logic signed [DIFF_W-1:0] diff;
	logic signed [SUM_W-1:0]  valley_sum;
	logic signed [SUM_W-1:0]  sum_next;
	logic                     phase_next;
	logic                     is_peak;
	logic                     is_valley;
	logic                     wrap_hit;
	logic [WRAP_W-1:0]        wrap_next;

	// Difference of the stored peak and the valley, and the sum with it swapped in.
	assign diff       = DIFF_W'({1'b0, peak_q}) - DIFF_W'({1'b0, item.sample});
	assign valley_sum = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(diff);

	assign is_peak   = (item.req_type == REQ_SAMPLE) && phase_peak_q;
	assign is_valley = (item.req_type == REQ_SAMPLE) && !phase_peak_q;
	assign wrap_hit  = is_valley && (pos_q == POS_LAST);
	assign wrap_next = wrap_hit ? wrap_q + 1'b1 : wrap_q;

	// Next sum and phase for the item in hand.
	always_comb begin
		sum_next   = sum_q;
		phase_next = phase_peak_q;
		if (is_peak) begin
			phase_next = 1'b0;
		end else if (is_valley) begin
			sum_next   = valley_sum;
			phase_next = 1'b1;
		end else if (sum_q[SUM_W-1]) begin
			// A read with a negative window flips the pair phase.
			phase_next = !phase_peak_q;
		end
	end

	// Result follows the updated state; a negative window reads as zero.
	always_comb begin
		result.average     = sum_next[SUM_W-1] ? '0 : sum_next[DEPTH_LOG2 +: SAMPLE_W];
		result.wrap_count  = wrap_next;
		result.expect_peak = phase_next;
	end

	// State registers advance once per processed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q       <= '0;
			phase_peak_q <= 1'b1;
			pos_q        <= '0;
			sum_q        <= '0;
			wrap_q       <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else if (step) begin
			phase_peak_q <= phase_next;
			sum_q        <= sum_next;
			wrap_q       <= wrap_next;
			if (is_peak) begin
				peak_q <= item.sample;
			end
			if (is_valley) begin
				ring_q[pos_q] <= diff;
				pos_q         <= wrap_hit ? '0 : pos_q + 1'b1;
			end
		end
	end

endmodule

### src/paired_sample_difference_averager_core.sv
// Paired sample difference averager.
// Path: input register, combinational ring read, subtract and add, then result register.
// Throughput: one beat per cycle while out_ready does not stall the result register.
// Reset: arst_n clears the ring, the window sum, the position and the wrap count,
// and sets the phase so the next sample is taken as a peak.
module paired_sample_difference_averager_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [psda_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [psda_pkg::SAMPLE_W-1:0] average,
	output logic [psda_pkg::WRAP_W-1:0]   wrap_count,
	output logic                          expect_peak
);
	import psda_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t result_comb;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;

	// The input stage moves on when the result register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.req_type <= req_type;
			item_s1.sample   <= sample;
		end
	end

	psda_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result_comb)
	);

	// Result register holds its beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_comb;
		end
	end

	assign out_valid   = valid_s2;
	assign average     = result_s2.average;
	assign wrap_count  = result_s2.wrap_count;
	assign expect_peak = result_s2.expect_peak;

endmodule
